@@ hw/rtl/fid_pkg.sv @@
// Package for the fall and inactivity detector: transaction types, codes and reset values.
`timescale 1ns / 1ps
`default_nettype none
package fid_pkg;

  localparam int unsigned IDLE_W  = 20;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned STILL_W = 8;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  // Register reset values: thresholds are squared raw counts, 1 g = 16384
  localparam logic [SQ_W-1:0]    RST_IMPACT_SQ   = 32'd603979776;  // (1.5 g)^2
  localparam logic [SQ_W-1:0]    RST_MOTION_LO   = 32'd67108864;   // (0.5 g)^2
  localparam logic [SQ_W-1:0]    RST_MOTION_HI   = 32'd603979776;  // (1.5 g)^2
  localparam logic [WAIT_W-1:0]  RST_SETTLE      = 16'd2000;
  localparam logic [STILL_W-1:0] RST_CONFIRM     = 8'd50;
  localparam logic [IDLE_W-1:0]  RST_INACT_LIMIT = 20'd60000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMPACT_SQ   = 3'd0,
    REG_MOTION_LO   = 3'd1,
    REG_MOTION_HI   = 3'd2,
    REG_SETTLE      = 3'd3,
    REG_CONFIRM     = 3'd4,
    REG_INACT_LIMIT = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_WATCH   = 2'd0,
    PH_WAIT    = 2'd1,
    PH_CONFIRM = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_ANALYSING = 2'd1,
    MODE_INACTIVE  = 2'd2
  } mode_t;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } item_t;

  typedef struct packed {
    logic [1:0] fall_phase;
    logic       impact_seen;
    logic       fall_confirmed;
    logic       fall_cancelled;
    logic       inactivity_alarm;
    logic [1:0] status_mode;
  } result_t;

  // Magnitude of a raw axis value; -32768 maps to 16'h8000
  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? (~v + 16'd1) : v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fall_and_inactivity_detector.sv @@
// Fall and inactivity detector top level: three-stage pipeline with state update in the last stage.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one transaction per clock: an accelerometer sample (command 0) or a
// millisecond tick (command 1), and returns exactly one result per transaction,
// in order. From acceptance to result_valid a transaction passes an input
// register, a stage that forms the squared magnitude x*x+y*y+z*z (three 16x16
// multipliers and an adder), and a stage that runs the compare-and-count state
// update into the result register. Throughput is one transaction per cycle as
// long as result_ready is high; the stages fill bubbles, so input stays open
// while a finished result waits until all stages are full. Configuration
// registers are written through cfg_we/cfg_index/cfg_data and must only
// change while no transaction is in flight; indexes above 5 are ignored.
module fall_and_inactivity_detector (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               item_valid,
  output logic                              item_ready,
  input  wire  fid_pkg::item_t              item,
  output logic                              result_valid,
  input  wire                               result_ready,
  output fid_pkg::result_t                  result,
  input  wire                               cfg_we,
  input  wire  [fid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [fid_pkg::CFG_W-1:0]         cfg_data
);
  import fid_pkg::*;

  // Configuration registers
  logic [SQ_W-1:0]    impact_sq;
  logic [SQ_W-1:0]    motion_lo;
  logic [SQ_W-1:0]    motion_hi;
  logic [WAIT_W-1:0]  settle_wait;
  logic [STILL_W-1:0] confirm_cnt;
  logic [IDLE_W-1:0]  inact_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      impact_sq   <= RST_IMPACT_SQ;
      motion_lo   <= RST_MOTION_LO;
      motion_hi   <= RST_MOTION_HI;
      settle_wait <= RST_SETTLE;
      confirm_cnt <= RST_CONFIRM;
      inact_limit <= RST_INACT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMPACT_SQ:   impact_sq   <= cfg_data;
        REG_MOTION_LO:   motion_lo   <= cfg_data;
        REG_MOTION_HI:   motion_hi   <= cfg_data;
        REG_SETTLE:      settle_wait <= cfg_data[WAIT_W-1:0];
        REG_CONFIRM:     confirm_cnt <= cfg_data[STILL_W-1:0];
        REG_INACT_LIMIT: inact_limit <= cfg_data[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when empty or when it drains downstream
  logic   s0_valid, s1_valid;
  logic   s0_load, s1_load, s2_load;
  item_t  s0_item;
  logic   s1_tick;
  logic [SQ_W-1:0] s1_mag_sq;

  assign s2_load    = !result_valid || result_ready;
  assign s1_load    = !s1_valid || s2_load;
  assign s0_load    = !s0_valid || s1_load;
  assign item_ready = s0_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s0_load) s0_valid     <= item_valid;
      if (s1_load) s1_valid     <= s0_valid;
      if (s2_load) result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_load && item_valid) s0_item <= item;
  end

  // Stage 1: squared magnitude. Max is 3 * 2^30, so 32 bits hold the sum.
  logic [15:0]     ax, ay, az;
  logic [SQ_W-1:0] sx, sy, sz;

  always_comb begin
    ax = abs16(s0_item.accel_x);
    ay = abs16(s0_item.accel_y);
    az = abs16(s0_item.accel_z);
    sx = ax * ax;
    sy = ay * ay;
    sz = az * az;
  end

  always_ff @(posedge clk) begin
    if (s1_load && s0_valid) begin
      s1_tick   <= (s0_item.command == CMD_TICK);
      s1_mag_sq <= sx + sy + sz;
    end
  end

  // Stage 2: detector state
  phase_t             phase_reg, phase_next;
  logic [WAIT_W-1:0]  wait_count, wait_count_next, wait_inc;
  logic [STILL_W-1:0] still_count, still_count_next, still_inc;
  logic [IDLE_W-1:0]  idle_count, idle_count_next;
  logic               alert_sent, alert_sent_next, alert_clr;
  logic               motion, impact_hit, alarm;
  logic               impact_c, confirmed_c, cancelled_c;
  mode_t              mode_c;
  logic               s2_fire;

  assign s2_fire = s2_load && s1_valid;

  always_comb begin
    motion     = !s1_tick && ((s1_mag_sq < motion_lo) || (s1_mag_sq > motion_hi));
    impact_hit = !s1_tick && (s1_mag_sq > impact_sq);
    wait_inc   = (s1_tick && (wait_count != WAIT_MAX)) ? wait_count + 1'b1 : wait_count;
    still_inc  = still_count + 1'b1;

    if (s1_tick) begin
      idle_count_next = (idle_count == IDLE_MAX) ? idle_count : idle_count + 1'b1;
    end else if (motion) begin
      idle_count_next = '0;
    end else begin
      idle_count_next = idle_count;
    end
    alert_clr       = motion ? 1'b0 : alert_sent;
    alarm           = (idle_count_next > inact_limit) && !alert_clr;
    alert_sent_next = alert_clr || alarm;
  end

  // Next state of the fall sequence
  always_comb begin
    phase_next       = phase_reg;
    wait_count_next  = wait_count;
    still_count_next = still_count;
    case (phase_reg)
      PH_WAIT: begin
        wait_count_next = wait_inc;
        if (wait_inc >= settle_wait) begin
          still_count_next = '0;
          phase_next       = PH_CONFIRM;
        end
      end
      PH_CONFIRM: begin
        if (!s1_tick) begin
          if (motion) begin
            phase_next = PH_WATCH;
          end else begin
            still_count_next = still_inc;
            if (still_inc >= confirm_cnt) phase_next = PH_WATCH;
          end
        end
      end
      default: begin
        // a stray phase code falls back to watching
        phase_next = PH_WATCH;
        if (impact_hit) begin
          wait_count_next = '0;
          phase_next      = PH_WAIT;
        end
      end
    endcase
  end

  // Result pulses and mode
  always_comb begin
    impact_c    = 1'b0;
    confirmed_c = 1'b0;
    cancelled_c = 1'b0;
    case (phase_reg)
      PH_WAIT: ;
      PH_CONFIRM: begin
        cancelled_c = !s1_tick && motion;
        confirmed_c = !s1_tick && !motion && (still_inc >= confirm_cnt);
      end
      default: impact_c = impact_hit;
    endcase
    if (alert_sent_next) begin
      mode_c = MODE_INACTIVE;
    end else if (phase_next != PH_WATCH) begin
      mode_c = MODE_ANALYSING;
    end else begin
      mode_c = MODE_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= PH_WATCH;
      wait_count  <= '0;
      still_count <= '0;
      idle_count  <= '0;
      alert_sent  <= 1'b0;
    end else if (s2_fire) begin
      phase_reg   <= phase_next;
      wait_count  <= wait_count_next;
      still_count <= still_count_next;
      idle_count  <= idle_count_next;
      alert_sent  <= alert_sent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      result.fall_phase       <= phase_next;
      result.impact_seen      <= impact_c;
      result.fall_confirmed   <= confirmed_c;
      result.fall_cancelled   <= cancelled_c;
      result.inactivity_alarm <= alarm;
      result.status_mode      <= mode_c;
    end
  end

  // Checks
  a_no_false_backpressure: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (s0_valid && s1_valid && result_valid && !result_ready))
    else $error("input stalled while the pipeline has room");

  a_single_fall_event: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({result.impact_seen, result.fall_confirmed,
                               result.fall_cancelled}))
    else $error("more than one fall event in one result");

  a_alarm_mode: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.inactivity_alarm) |-> (result.status_mode == MODE_INACTIVE))
    else $error("alarm raised without inactive mode");

  a_impact_enters_wait: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && impact_c) |=> (phase_reg == PH_WAIT && wait_count == '0))
    else $error("impact did not start the settle wait");

  a_end_returns_watch: assert property (@(posedge clk) disable iff (rst)
    (s2_fire && (confirmed_c || cancelled_c)) |=> (phase_reg == PH_WATCH))
    else $error("fall decision did not return to watching");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for fall_and_inactivity_detector: directed and random streams.
`timescale 1ns / 1ps
module tb;
  import fid_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [SQ_W-1:0] SQ_CEIL = 32'hC000_0000;
  localparam int PHASE_ITEMS = 100;
  localparam int RANDOM_PHASES = 9;

  typedef enum int {SK_STILL, SK_LOW, SK_HIGH, SK_NOISE} sample_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  fall_and_inactivity_detector dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Detector copy: configuration and state
  logic [SQ_W-1:0] cf_impact, cf_low, cf_high;
  logic [15:0] cf_settle;
  logic [7:0] cf_confirm;
  logic [19:0] cf_limit;
  phase_t st_phase;
  logic [15:0] st_wait;
  logic [7:0] st_still;
  logic [19:0] st_idle;
  logic st_alert;

  result_t pending_outcomes[$];
  result_t want;
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;
  bit rx_stalls = 1'b1;
  bit rx_on = 1'b1;
  int rx_left = 0;

  function automatic longint unsigned axis_sq(input logic [15:0] u);
    logic [16:0] mag;
    longint unsigned mg;
    mag = u[15] ? (17'h10000 - {1'b0, u}) : {1'b0, u};
    mg = mag;
    return mg * mg;
  endfunction

  function automatic result_t next_outcome(input item_t it);
    result_t r;
    logic is_tick;
    logic motion;
    longint unsigned m;
    r = '0;
    motion = 1'b0;
    is_tick = (it.command == CMD_TICK);
    m = axis_sq(it.accel_x) + axis_sq(it.accel_y) + axis_sq(it.accel_z);
    if (is_tick) begin
      if (st_idle != '1) st_idle = st_idle + 20'd1;
    end else begin
      motion = (m < cf_low) || (m > cf_high);
      if (motion) begin
        st_idle = '0;
        st_alert = 1'b0;
      end
    end
    if (st_idle > cf_limit && !st_alert) begin
      r.inactivity_alarm = 1'b1;
      st_alert = 1'b1;
    end
    case (st_phase)
      PH_WAIT: begin
        if (is_tick && st_wait != '1) st_wait = st_wait + 16'd1;
        // the item that ends the wait is not counted as still
        if (st_wait >= cf_settle) begin
          st_still = '0;
          st_phase = PH_CONFIRM;
        end
      end
      PH_CONFIRM: begin
        if (!is_tick) begin
          if (motion) begin
            r.fall_cancelled = 1'b1;
            st_phase = PH_WATCH;
          end else begin
            st_still = st_still + 8'd1;
            if (st_still >= cf_confirm) begin
              r.fall_confirmed = 1'b1;
              st_phase = PH_WATCH;
            end
          end
        end
      end
      default: begin
        if (!is_tick && m > cf_impact) begin
          r.impact_seen = 1'b1;
          st_wait = '0;
          st_phase = PH_WAIT;
        end
      end
    endcase
    r.fall_phase = st_phase;
    if (st_alert) r.status_mode = MODE_INACTIVE;
    else if (st_phase != PH_WATCH) r.status_mode = MODE_ANALYSING;
    else r.status_mode = MODE_NORMAL;
    return r;
  endfunction

  function automatic logic [15:0] rnd_span(input int n);
    return 16'($urandom_range(0, 2 * n) - n);
  endfunction

  function automatic item_t sample(input logic [15:0] x, y, z);
    item_t it;
    it.command = CMD_SAMPLE;
    it.accel_x = x;
    it.accel_y = y;
    it.accel_z = z;
    return it;
  endfunction

  function automatic item_t tick();
    item_t it;
    it.command = CMD_TICK;
    // axis data is ignored on ticks, so fill it with junk
    it.accel_x = 16'($urandom);
    it.accel_y = 16'($urandom);
    it.accel_z = 16'($urandom);
    return it;
  endfunction

  function automatic item_t mk_sample(input sample_kind_t k);
    logic [15:0] zm;
    item_t it;
    it = sample(rnd_span(4000), rnd_span(4000), rnd_span(4000));
    case (k)
      SK_STILL: begin
        zm = 16'($urandom_range(14384, 18384));
        it.accel_x = rnd_span(3000);
        it.accel_y = rnd_span(3000);
        it.accel_z = $urandom_range(0, 1) ? -zm : zm;
      end
      SK_HIGH: begin
        zm = 16'($urandom_range(26000, 32767));
        it.accel_x = rnd_span(8000);
        it.accel_y = rnd_span(8000);
        it.accel_z = $urandom_range(0, 1) ? -zm : zm;
        if ($urandom_range(0, 7) == 0) it.accel_z = 16'h8000;
      end
      SK_NOISE: begin
        it.accel_x = 16'($urandom);
        it.accel_y = 16'($urandom);
        it.accel_z = 16'($urandom);
      end
      default: ;
    endcase
    return it;
  endfunction

  // Holds valid high until the handshake, then records the predicted outcome.
  task automatic send_item(input item_t it);
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pending_outcomes.push_back(next_outcome(it));
    items_sent++;
  endtask

  task automatic feed(input item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on && $urandom_range(0, 2) != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    send_item(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_IMPACT_SQ:   cf_impact = data;
      REG_MOTION_LO:   cf_low = data;
      REG_MOTION_HI:   cf_high = data;
      REG_SETTLE:      cf_settle = data[15:0];
      REG_CONFIRM:     cf_confirm = data[7:0];
      REG_INACT_LIMIT: cf_limit = data[19:0];
      default: ;
    endcase
  endtask

  // Narrow registers get junk in the unused upper data bits.
  task automatic set_config(input logic [31:0] impact, low, high,
                            input int settle, confirm, limit);
    drain();
    write_reg(REG_IMPACT_SQ, impact);
    write_reg(REG_MOTION_LO, low);
    write_reg(REG_MOTION_HI, high);
    write_reg(REG_SETTLE, $urandom & 32'hFFFF_0000 | 32'(settle));
    write_reg(REG_CONFIRM, $urandom & 32'hFFFF_FF00 | 32'(confirm));
    write_reg(REG_INACT_LIMIT, $urandom & 32'hFFF0_0000 | 32'(limit));
    write_reg(REG_UNUSED, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic test_field_extremes();
    feed(sample(16'h0000, 16'h0000, 16'h0000));
    feed(sample(16'h8000, 16'h8000, 16'h8000));
    feed(sample(16'h7FFF, 16'h7FFF, 16'h7FFF));
    feed(sample(16'h8000, 16'h7FFF, 16'h0000));
    feed(tick());
    feed(tick());
    feed(sample(16'h0000, 16'h0000, 16'd16384));
    feed(sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
    // top of the threshold range: full-scale vector is neither impact nor motion
    set_config(SQ_CEIL, SQ_CEIL, SQ_CEIL, 1, 1, 1);
    feed(sample(16'h8000, 16'h8000, 16'h8000));
    feed(sample(16'h0000, 16'h0000, 16'h0000));
    feed(tick());
    feed(tick());
  endtask

  task automatic test_zero_settings();
    set_config(RST_IMPACT_SQ, RST_MOTION_LO, RST_MOTION_HI, 0, 0, 0);
    feed(mk_sample(SK_LOW));
    feed(tick());
    feed(tick());
    feed(mk_sample(SK_HIGH));
    feed(tick());
    feed(mk_sample(SK_STILL));
    feed(mk_sample(SK_HIGH));
    feed(mk_sample(SK_STILL));
    feed(mk_sample(SK_STILL));
    feed(mk_sample(SK_HIGH));
    feed(mk_sample(SK_STILL));
    feed(mk_sample(SK_LOW));
  endtask

  // Long settle time back to back: the wait ends exactly on the last tick.
  task automatic test_long_settle();
    gaps_on = 1'b0;
    set_config(RST_IMPACT_SQ, RST_MOTION_LO, RST_MOTION_HI, 64, 1, 20'hFFFFF);
    feed(sample(16'h0000, 16'h0000, 16'h8000));
    repeat (64) feed(tick());
    feed(mk_sample(SK_STILL));
    feed(mk_sample(SK_STILL));
    gaps_on = 1'b1;
  endtask

  task automatic run_fall();
    int n;
    int cancel_at;
    feed(mk_sample(SK_HIGH));
    n = int'(cf_settle) + $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) feed(mk_sample(SK_STILL));
      feed(tick());
    end
    n = int'(cf_confirm) + 1;
    cancel_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == cancel_at) begin
        feed(mk_sample($urandom_range(0, 1) ? SK_LOW : SK_HIGH));
        break;
      end
      feed(mk_sample(SK_STILL));
      if ($urandom_range(0, 4) == 0) feed(tick());
    end
  endtask

  task automatic run_idle();
    int n;
    n = (cf_limit > 56) ? 60 : int'(cf_limit) + $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) feed(mk_sample(SK_STILL));
      else feed(tick());
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 3))
        0: feed(tick());
        1: feed(mk_sample(SK_LOW));
        2: feed(mk_sample(SK_HIGH));
        default: feed(mk_sample(SK_NOISE));
      endcase
    end
  endtask

  task automatic test_random_streams();
    int start;
    int pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gaps_on = (p % 3 != 1);
      rx_stalls = (p % 3 != 2);
      case (p)
        0: set_config(RST_IMPACT_SQ, RST_MOTION_LO, RST_MOTION_HI, 5, 3, 10);
        1: set_config(32'h0, 32'h0, 32'h0, 0, 1, 0);
        2: set_config(RST_IMPACT_SQ, 32'h0, 32'hFFFF_FFFF, 1, 255, 20'hFFFFF);
        default: set_config($urandom_range(300_000_000, 900_000_000),
                            $urandom_range(30_000_000, 150_000_000),
                            $urandom_range(400_000_000, 800_000_000),
                            $urandom_range(0, 25), $urandom_range(1, 30),
                            ($urandom_range(0, 4) == 0) ? $urandom_range(1000, 1048575)
                                                        : $urandom_range(0, 40));
      endcase
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) run_fall();
        else if (pick < 7) run_idle();
        else run_noise();
        // occasional full hold-off until the pipeline is empty
        if ($urandom_range(0, 9) == 0) drain();
      end
    end
    gaps_on = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // Receiver: ready and stall runs of random length; stalls only while rx_stalls is set
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_on = !rx_on || !rx_stalls;
      rx_left = rx_on ? $urandom_range(1, 24) : $urandom_range(1, 10);
    end else begin
      rx_left--;
    end
    result_ready <= rx_on;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("cycle %0d: result %h with no transaction pending", cycle_count, result);
      end else begin
        want = pending_outcomes.pop_front();
        if (result.fall_phase !== want.fall_phase ||
            result.impact_seen !== want.impact_seen ||
            result.fall_confirmed !== want.fall_confirmed ||
            result.fall_cancelled !== want.fall_cancelled ||
            result.inactivity_alarm !== want.inactivity_alarm ||
            result.status_mode !== want.status_mode) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"cycle %0d: expected phase=%0d imp=%b conf=%b canc=%b alarm=%b mode=%0d,",
                      " got phase=%0d imp=%b conf=%b canc=%b alarm=%b mode=%0d"},
                     cycle_count, want.fall_phase, want.impact_seen, want.fall_confirmed,
                     want.fall_cancelled, want.inactivity_alarm, want.status_mode,
                     result.fall_phase, result.impact_seen, result.fall_confirmed,
                     result.fall_cancelled, result.inactivity_alarm, result.status_mode);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    cf_impact = RST_IMPACT_SQ;
    cf_low = RST_MOTION_LO;
    cf_high = RST_MOTION_HI;
    cf_settle = RST_SETTLE;
    cf_confirm = RST_CONFIRM;
    cf_limit = RST_INACT_LIMIT;
    st_phase = PH_WATCH;
    st_wait = '0;
    st_still = '0;
    st_idle = '0;
    st_alert = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_zero_settings();
    test_long_settle();
    test_random_streams();
    drain();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
